// ----- src/cssb_pkg.sv -----
// Shared types and constants for the cosine similarity batch search block.
`default_nettype none
package cssb_pkg;

    // Element width and Q1.15 fraction bits
    localparam int ElemBits = 16;
    localparam int FracBits = 15;
    localparam int SimBits  = 16;
    localparam int IdxBits  = 16;

    // Depth of the job queue between front and back
    localparam int QDepth   = 2;

    // Register indexes (byte address bit 2)
    localparam logic RegVectorLength = 1'b0;
    localparam logic RegBatchCount   = 1'b1;

    localparam int LenBits   = 11;
    localparam int BatchBits = 16;

    // Item modes
    localparam logic ModeQuery  = 1'b0;
    localparam logic ModeCorpus = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic signed [ElemBits-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SimBits-1:0]   similarity;
        logic        [IdxBits-1:0]   vector_index;
        logic                        zero_norm;
        logic                        last_of_batch;
    } t_out_item;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_SQRT,
        BS_DIV,
        BS_OUT
    } t_bstate;

endpackage
`default_nettype wire

// ----- src/cssb_queue.sv -----
// Small FIFO that carries finished-vector jobs from front to back.
`default_nettype none
module cssb_queue #(
    parameter int W = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_push,
    input  wire logic [W-1:0]                             i_data,
    input  wire logic                                     i_pop,
    output logic      [W-1:0]                             o_data,
    output logic                                          o_empty,
    output logic      [$clog2(cssb_pkg::QDepth+1)-1:0]    o_level
);
    localparam int PW = $clog2(cssb_pkg::QDepth);
    localparam int LW = $clog2(cssb_pkg::QDepth+1);

    logic [W-1:0]  r_mem [cssb_pkg::QDepth];
    logic [PW-1:0] r_wp, r_rp;
    logic [LW-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(cssb_pkg::QDepth-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(cssb_pkg::QDepth-1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_level = r_count;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != LW'(cssb_pkg::QDepth)))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue underflow");
`endif
endmodule
`default_nettype wire

// ----- src/cssb_front.sv -----
// Front end: takes elements, keeps the query store and the running sums.
`default_nettype none
module cssb_front #(
    parameter int MAX_LENGTH = 1024
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    input  wire cssb_pkg::t_in_item                       i_in,
    output logic                                          o_stall,
    input  wire logic [cssb_pkg::LenBits-1:0]             i_vector_length,
    input  wire logic [cssb_pkg::BatchBits-1:0]           i_batch_count,
    input  wire logic [$clog2(cssb_pkg::QDepth+1)-1:0]    i_q_level,
    output logic                                          o_push,
    output logic [2*(2*cssb_pkg::ElemBits-1+$clog2(MAX_LENGTH))
                  + 2*cssb_pkg::ElemBits+$clog2(MAX_LENGTH)
                  + cssb_pkg::IdxBits:0]                  o_job
);
    localparam int E  = cssb_pkg::ElemBits;
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = AW + 1;
    localparam int NW = 2*E - 1 + AW;
    localparam int DW = 2*E + AW;
    localparam int LW = $clog2(cssb_pkg::QDepth+1);

    logic signed [E-1:0] r_qmem [MAX_LENGTH];

    logic                      r_cur_mode;
    logic [CW-1:0]             r_elem;
    logic [cssb_pkg::IdxBits-1:0] r_vcnt;

    logic                      r_b_valid, r_b_mode, r_b_first, r_b_done, r_b_last;
    logic signed [E-1:0]       r_b_x, r_b_q;
    logic [cssb_pkg::IdxBits-1:0] r_b_vidx;

    logic [NW-1:0]             r_qn, r_vn;
    logic signed [DW-1:0]      r_dot;

    logic                      accept;
    logic [CW-1:0]             len, idx;
    logic                      done, vlast;
    logic [LW:0]               need;
    logic signed [2*E-1:0]     sq_full, prod;
    logic [NW-1:0]             sq, qn_n, vn_n;
    logic signed [DW-1:0]      dot_n;

    // hold input while the queue might not take a job
    always_comb begin
        need    = (LW+1)'(i_q_level) + (LW+1)'(r_b_valid && r_b_mode && r_b_done)
                  + (LW+1)'(1);
        o_stall = (need > (LW+1)'(cssb_pkg::QDepth));
        accept  = i_valid && !o_stall;
    end

    // effective length and element position
    always_comb begin
        if (i_vector_length == '0) begin
            len = CW'(1);
        end else if (32'(i_vector_length) > 32'(MAX_LENGTH)) begin
            len = CW'(MAX_LENGTH);
        end else begin
            len = CW'(i_vector_length);
        end
        idx   = (i_in.mode != r_cur_mode) ? '0 : r_elem;
        done  = ((CW+1)'(idx) + (CW+1)'(1)) >= (CW+1)'(len);
        vlast = (r_vcnt == (i_batch_count - 1'b1));
    end

    // query store: write on query items, registered read on corpus items
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in.mode == cssb_pkg::ModeQuery) begin
                r_qmem[idx[AW-1:0]] <= i_in.sample;
            end
            r_b_q <= r_qmem[idx[AW-1:0]];
        end
    end

    // stage A: counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode <= cssb_pkg::ModeQuery;
            r_elem     <= '0;
            r_vcnt     <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            r_b_valid <= accept;
            if (accept) begin
                r_cur_mode <= i_in.mode;
                r_elem     <= done ? '0 : idx + 1'b1;
                if (i_in.mode == cssb_pkg::ModeQuery && idx == '0) begin
                    r_vcnt <= '0;
                end else if (i_in.mode == cssb_pkg::ModeCorpus && done) begin
                    r_vcnt <= vlast ? '0 : r_vcnt + 1'b1;
                end
            end
        end
    end

    // stage A: payload toward stage B
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_mode  <= i_in.mode;
            r_b_first <= (idx == '0);
            r_b_done  <= done;
            r_b_x     <= i_in.sample;
            r_b_vidx  <= r_vcnt;
            r_b_last  <= vlast;
        end
    end

    // stage B: products and sums
    always_comb begin
        sq_full = r_b_x * r_b_x;
        prod    = r_b_x * r_b_q;
        sq      = NW'(sq_full[2*E-2:0]);
        qn_n    = r_b_first ? sq : r_qn + sq;
        vn_n    = r_b_first ? sq : r_vn + sq;
        dot_n   = r_b_first ? DW'(prod) : r_dot + DW'(prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn  <= '0;
            r_vn  <= '0;
            r_dot <= '0;
        end else if (r_b_valid) begin
            if (r_b_mode == cssb_pkg::ModeQuery) begin
                r_qn <= qn_n;
            end else begin
                r_vn  <= vn_n;
                r_dot <= dot_n;
            end
        end
    end

    // finished corpus vector becomes a job
    assign o_push = r_b_valid && (r_b_mode == cssb_pkg::ModeCorpus) && r_b_done;
    assign o_job  = {r_qn, vn_n, dot_n, r_b_vidx, r_b_last};

endmodule
`default_nettype wire

// ----- src/cssb_back.sv -----
// Back end: norm product, integer square root, division and saturation.
`default_nettype none
module cssb_back #(
    parameter int MAX_LENGTH = 1024
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_empty,
    input  wire logic [2*(2*cssb_pkg::ElemBits-1+$clog2(MAX_LENGTH))
                       + 2*cssb_pkg::ElemBits+$clog2(MAX_LENGTH)
                       + cssb_pkg::IdxBits:0]             i_job,
    output logic                                          o_pop,
    output logic                                          o_valid,
    input  wire logic                                     i_stall,
    output cssb_pkg::t_out_item                           o_out
);
    localparam int E  = cssb_pkg::ElemBits;
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int NW = 2*E - 1 + AW;
    localparam int DW = 2*E + AW;
    localparam int RW = NW + 3;
    localparam int KW = $clog2(NW+1);
    localparam int FB = cssb_pkg::FracBits;
    localparam int SB = cssb_pkg::SimBits;

    cssb_pkg::t_bstate r_state, n_state;

    logic [NW-1:0]            j_qn, j_vn;
    logic signed [DW-1:0]     j_dot;
    logic [cssb_pkg::IdxBits-1:0] j_vidx;
    logic                     j_last;

    logic [NW-1:0]            r_a, r_b, r_root;
    logic [2*NW-1:0]          r_p;
    logic [RW-1:0]            r_rem;
    logic [NW:0]              r_drem;
    logic [NW-1:0]            r_mag;
    logic                     r_neg;
    logic [FB-1:0]            r_quo;
    logic [KW-1:0]            r_cnt;
    cssb_pkg::t_out_item      r_out;

    logic [RW-1:0]            sh, trial;
    logic [NW:0]              dsh;
    logic [DW-1:0]            mag_full;
    logic                     cnt_end;

    assign {j_qn, j_vn, j_dot, j_vidx, j_last} = i_job;

    always_comb begin
        sh       = {r_rem[RW-3:0], r_p[2*NW-1 -: 2]};
        trial    = RW'({r_root, 2'b01});
        dsh      = {r_drem[NW-1:0], 1'b0};
        mag_full = j_dot[DW-1] ? DW'(-j_dot) : DW'(j_dot);
        cnt_end  = (r_cnt == '0);
    end

    // quotient including the bit decided this cycle
    function automatic logic [FB-1:0] quo_next();
        logic bit_n;
        bit_n = (dsh >= (NW+1)'(r_root));
        return {r_quo[FB-2:0], bit_n};
    endfunction

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cssb_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            cssb_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = (j_qn == '0 || j_vn == '0) ? cssb_pkg::BS_OUT
                                                        : cssb_pkg::BS_MUL;
                end
            end
            cssb_pkg::BS_MUL:  if (cnt_end) n_state = cssb_pkg::BS_SQRT;
            cssb_pkg::BS_SQRT: if (cnt_end) n_state = cssb_pkg::BS_DIV;
            cssb_pkg::BS_DIV: begin
                if (cnt_end) n_state = cssb_pkg::BS_OUT;
            end
            cssb_pkg::BS_OUT:  if (!i_stall) n_state = cssb_pkg::BS_IDLE;
            default:           n_state = cssb_pkg::BS_IDLE;
        endcase
    end

    // datapath: shift-add multiply, digit-by-digit root, long division
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cssb_pkg::BS_IDLE: begin
                r_a   <= j_qn;
                r_b   <= j_vn;
                r_p   <= '0;
                r_cnt <= KW'(NW-1);
                r_neg <= j_dot[DW-1];
                r_mag <= NW'(mag_full);
                r_out.vector_index  <= j_vidx;
                r_out.last_of_batch <= j_last;
                r_out.zero_norm     <= (j_qn == '0 || j_vn == '0);
                r_out.similarity    <= '0;
            end
            cssb_pkg::BS_MUL: begin
                r_p   <= {r_p[2*NW-2:0], 1'b0} + (r_b[NW-1] ? (2*NW)'(r_a) : '0);
                r_b   <= {r_b[NW-2:0], 1'b0};
                r_cnt <= cnt_end ? KW'(NW-1) : r_cnt - 1'b1;
                r_rem  <= '0;
                r_root <= '0;
            end
            cssb_pkg::BS_SQRT: begin
                r_p <= {r_p[2*NW-3:0], 2'b00};
                if (sh >= trial) begin
                    r_rem  <= sh - trial;
                    r_root <= {r_root[NW-2:0], 1'b1};
                end else begin
                    r_rem  <= sh;
                    r_root <= {r_root[NW-2:0], 1'b0};
                end
                r_cnt  <= cnt_end ? KW'(FB-1) : r_cnt - 1'b1;
                r_drem <= (NW+1)'(r_mag);
                r_quo  <= '0;
            end
            cssb_pkg::BS_DIV: begin
                r_cnt <= r_cnt - 1'b1;
                if (dsh >= (NW+1)'(r_root)) begin
                    r_drem <= dsh - (NW+1)'(r_root);
                    r_quo  <= {r_quo[FB-2:0], 1'b1};
                end else begin
                    r_drem <= dsh;
                    r_quo  <= {r_quo[FB-2:0], 1'b0};
                end
            end
            cssb_pkg::BS_OUT: begin
                if (r_state != n_state && !r_out.zero_norm) begin
                    r_out.similarity <= r_out.similarity;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        // result formed as division ends; saturate when |dot| reaches the root
        if (r_state == cssb_pkg::BS_DIV && cnt_end) begin
            if (r_mag >= r_root) begin
                r_out.similarity <= r_neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            end else begin
                r_out.similarity <= r_neg ? -SB'(quo_next()) : SB'(quo_next());
            end
        end
    end

    assign o_valid = (r_state == cssb_pkg::BS_OUT);
    assign o_out   = r_out;

`ifndef SYNTH
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cssb_pkg::BS_DIV && r_mag < r_root) |-> (r_drem < (NW+1)'(r_root)))
        else $error("division remainder out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == cssb_pkg::BS_IDLE && !i_empty))
        else $error("job taken while busy");
`endif
endmodule
`default_nettype wire

// ----- src/cosine_similarity_batch_search.sv -----
// Top level: configuration registers, front end, job queue and back end.
//
//  channel  | valid / stall          | payload
//  ---------+------------------------+---------------------------------
//  input    | i_valid / o_stall      | i_in  (mode, sample)
//  output   | o_valid / i_stall      | o_out (similarity, index, flags)
//  config   | APB psel/penable/pready| paddr, pwdata, prdata
//
// Elements are taken one per cycle; the front end stalls only when the
// two-entry job queue could overflow. Each finished corpus vector passes the
// back end as a pop, a shift-add norm product, a bit-pair square root, a
// 15-step division and an output state; a zero norm goes from the pop
// straight to the output state. Reset is synchronous and needs no clearing
// pass. A stalled result holds while the front keeps accumulating.
`default_nettype none
module cosine_similarity_batch_search #(
    parameter int MAX_LENGTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire cssb_pkg::t_in_item   i_in,
    output logic                      o_stall,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output cssb_pkg::t_out_item       o_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    localparam int E  = cssb_pkg::ElemBits;
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int NW = 2*E - 1 + AW;
    localparam int DW = 2*E + AW;
    localparam int JW = 2*NW + DW + cssb_pkg::IdxBits + 1;
    localparam int LW = $clog2(cssb_pkg::QDepth+1);

    logic [cssb_pkg::LenBits-1:0]   r_vector_length;
    logic [cssb_pkg::BatchBits-1:0] r_batch_count;

    logic          push, pop, empty;
    logic [JW-1:0] job_in, job_out;
    logic [LW-1:0] level;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= cssb_pkg::LenBits'(1024);
            r_batch_count   <= cssb_pkg::BatchBits'(1);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                cssb_pkg::RegVectorLength: r_vector_length <= pwdata[cssb_pkg::LenBits-1:0];
                cssb_pkg::RegBatchCount:   r_batch_count   <= pwdata[cssb_pkg::BatchBits-1:0];
                default:                   r_batch_count   <= r_batch_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cssb_pkg::RegVectorLength: prdata = 32'(r_vector_length);
            cssb_pkg::RegBatchCount:   prdata = 32'(r_batch_count);
            default:                   prdata = '0;
        endcase
    end

    cssb_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_in            (i_in),
        .o_stall         (o_stall),
        .i_vector_length (r_vector_length),
        .i_batch_count   (r_batch_count),
        .i_q_level       (level),
        .o_push          (push),
        .o_job           (job_in)
    );

    cssb_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty),
        .o_level (level)
    );

    cssb_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the cosine similarity batch search block.
`default_nettype none
module tb_top;

    localparam int MaxLen = 1024;
    localparam int Watchdog = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    cssb_pkg::t_in_item    i_in = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    cssb_pkg::t_out_item   o_out;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    cosine_similarity_batch_search #(.MAX_LENGTH(MaxLen)) u_top (
        .i_clk, .i_rst_n, .i_valid, .i_in, .o_stall, .o_valid, .i_stall, .o_out,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    // Pending items, expected similarity results, traffic knobs
    cssb_pkg::t_in_item  pending_items[$];
    cssb_pkg::t_out_item expected_sims[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles = 0;
    int        quiet_cycles = 0;
    int        items_queued = 0;
    bit        failed = 1'b0;

    // Shadow state of the block
    logic signed [15:0] q_mem[MaxLen];
    logic [63:0]        q_norm, c_norm;
    logic signed [63:0] dot_sum;
    int unsigned        elem_pos, vec_pos, cur_len, cur_batch;
    logic               last_mode;

    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tt;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tt = {64'd0, t} * {64'd0, t};
            if (tt <= n) r = t;
        end
        return r;
    endfunction

    // Update the shadow state with one accepted item
    task automatic model_element(cssb_pkg::t_in_item it);
        logic signed [63:0] x;
        logic [63:0]        sq, mag, quo, den;
        logic [15:0]        sim;
        logic               done, neg, zero, last;
        int unsigned        idx;
        cssb_pkg::t_out_item r;
        x = 64'(it.sample);
        sq = x * x;
        if (it.mode != last_mode) elem_pos = 0;
        last_mode = it.mode;
        idx = elem_pos;
        done = (idx + 1 >= cur_len);
        if (it.mode == cssb_pkg::ModeQuery) begin
            if (idx == 0) begin
                q_norm = '0;
                vec_pos = 0;
            end
            q_mem[idx] = it.sample;
            q_norm += sq;
            elem_pos = done ? 0 : idx + 1;
        end else begin
            if (idx == 0) begin
                dot_sum = '0;
                c_norm = '0;
            end
            dot_sum += 64'(q_mem[idx]) * x;
            c_norm += sq;
            if (!done) begin
                elem_pos = idx + 1;
            end else begin
                elem_pos = 0;
                sim = '0;
                zero = (q_norm == 0 || c_norm == 0);
                if (!zero) begin
                    den = int_sqrt({64'd0, q_norm} * {64'd0, c_norm});
                    neg = dot_sum[63];
                    mag = neg ? -dot_sum : dot_sum;
                    quo = (mag * 64'd32768) / den;
                    if (neg) sim = (quo >= 32768) ? 16'h8000 : 16'(-quo);
                    else sim = (quo >= 32768) ? 16'h7fff : 16'(quo);
                end
                last = (vec_pos == ((cur_batch - 1) & 16'hffff));
                r.similarity = sim;
                r.vector_index = 16'(vec_pos);
                r.zero_norm = zero;
                r.last_of_batch = last;
                expected_sims.push_back(r);
                vec_pos = last ? 0 : ((vec_pos + 1) & 16'hffff);
            end
        end
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) model_element(i_in);
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sims.size() == 0) begin
                $display("%0t: unexpected item %h", $time, o_out);
                failed = 1'b1;
            end else begin
                cssb_pkg::t_out_item e;
                e = expected_sims.pop_front();
                if (o_out.similarity !== e.similarity)
                    $display("%0t: similarity exp %0d got %0d", $time,
                             e.similarity, o_out.similarity);
                if (o_out.vector_index !== e.vector_index)
                    $display("%0t: vector_index exp %0d got %0d", $time,
                             e.vector_index, o_out.vector_index);
                if (o_out.zero_norm !== e.zero_norm)
                    $display("%0t: zero_norm exp %0b got %0b", $time,
                             e.zero_norm, o_out.zero_norm);
                if (o_out.last_of_batch !== e.last_of_batch)
                    $display("%0t: last_of_batch exp %0b got %0b", $time,
                             e.last_of_batch, o_out.last_of_batch);
                if (o_out !== e) failed = 1'b1;
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= Watchdog) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_elem(logic mode, logic [15:0] s);
        cssb_pkg::t_in_item it;
        it.mode = mode;
        it.sample = s;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_sims.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic reg_write(logic reg_idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Reprogram between phases, mirroring the registers in the shadow state
    task automatic setup_phase(int len, int batch, int idle, int stall);
        wait_drained();
        reg_write(cssb_pkg::RegVectorLength, len);
        reg_write(cssb_pkg::RegBatchCount, batch);
        cur_len = len;
        cur_batch = (batch == 0) ? 65536 : batch;
        send_idle_pct = idle;
        recv_stall_pct = stall;
    endtask

    // Random phase: full query, then corpus vectors with some broken sequences
    task automatic random_phase(int len, int batch, int nvec, int idle, int stall);
        int k;
        setup_phase(len, batch, idle, stall);
        for (int i = 0; i < len; i++) push_elem(cssb_pkg::ModeQuery, rand_sample());
        for (int v = 0; v < nvec; v++) begin
            if (len > 1 && $urandom_range(9) == 0) begin
                // dropped corpus vector followed by a partial query reload
                k = $urandom_range(1, len - 1);
                for (int i = 0; i < k; i++) push_elem(cssb_pkg::ModeCorpus, rand_sample());
                k = $urandom_range(1, len - 1);
                for (int i = 0; i < k; i++) push_elem(cssb_pkg::ModeQuery, rand_sample());
            end
            for (int i = 0; i < len; i++)
                push_elem(cssb_pkg::ModeCorpus,
                          $urandom_range(19) == 0 ? 16'h0 : rand_sample());
        end
    endtask

    initial begin
        int len;
        int batch;
        int ph;
        last_mode = cssb_pkg::ModeQuery;
        elem_pos = 0;
        vec_pos = 0;
        q_norm = '0;
        c_norm = '0;
        dot_sum = '0;
        cur_len = 1024;
        cur_batch = 1;
        for (int i = 0; i < MaxLen; i++) q_mem[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, matching, opposite and zero vectors, batch wrap
        setup_phase(4, 3, 0, 0);
        push_elem(cssb_pkg::ModeQuery, 16'h8000);
        push_elem(cssb_pkg::ModeQuery, 16'h7fff);
        push_elem(cssb_pkg::ModeQuery, 16'hffff);
        push_elem(cssb_pkg::ModeQuery, 16'h0001);
        push_elem(cssb_pkg::ModeCorpus, 16'h8000);
        push_elem(cssb_pkg::ModeCorpus, 16'h7fff);
        push_elem(cssb_pkg::ModeCorpus, 16'hffff);
        push_elem(cssb_pkg::ModeCorpus, 16'h0001);
        push_elem(cssb_pkg::ModeCorpus, 16'h7fff);
        push_elem(cssb_pkg::ModeCorpus, 16'h8001);
        push_elem(cssb_pkg::ModeCorpus, 16'h0001);
        push_elem(cssb_pkg::ModeCorpus, 16'hffff);
        for (int i = 0; i < 4; i++) push_elem(cssb_pkg::ModeCorpus, 16'h0);
        for (int i = 0; i < 4; i++) push_elem(cssb_pkg::ModeCorpus, 16'h5555);
        // zero query gives zero norm
        for (int i = 0; i < 4; i++) push_elem(cssb_pkg::ModeQuery, 16'h0);
        for (int i = 0; i < 4; i++) push_elem(cssb_pkg::ModeCorpus, 16'haaaa);

        // Shortest length, longer lengths and batch count extremes
        random_phase(1, 1, 6, 0, 0);
        random_phase(96, 65535, 2, 0, 0);
        random_phase(3, 65535, 4, 27, 27);

        // Long receiver hold while the sender keeps offering items
        setup_phase(2, 4, 0, 0);
        hold_cycles = 600;
        for (int i = 0; i < 2; i++) push_elem(cssb_pkg::ModeQuery, rand_sample());
        for (int i = 0; i < 40; i++) push_elem(cssb_pkg::ModeCorpus, rand_sample());

        // Random phases cycling through the idling patterns
        ph = 0;
        while (items_queued < 1200) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
            batch = ($urandom_range(7) == 0) ? 65535 : $urandom_range(1, 5);
            case (ph % 4)
                0: random_phase(len, batch, $urandom_range(3, 12), 0, 0);
                1: random_phase(len, batch, $urandom_range(3, 12), 75, 0);
                2: random_phase(len, batch, $urandom_range(3, 12), 0, 75);
                default: random_phase(len, batch, $urandom_range(3, 12), 27, 27);
            endcase
            ph++;
        end

        wait_drained();
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
